@@ design/bcbm_pkg.sv @@
// ---------------------------------------------------------------------------
// bcbm_pkg - shared constants for the banked cartridge bus mapper
// Operation codes, I/O port numbers, field widths and store sizes.
// ---------------------------------------------------------------------------
package bcbm_pkg;

  // field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 17;
  localparam int DATA_W  = 8;
  localparam int PAGE_W  = 6;
  localparam int BANK_W  = 5;
  localparam int KPTR_W  = 16;

  // store sizes
  localparam int CART_BYTES_DEF = 131072;
  localparam int BANK_BYTES     = 8192;
  localparam int KANJI_BYTES    = 131072;
  localparam int RAM_BYTES      = 8192;
  localparam int OFFS_W  = $clog2(BANK_BYTES);
  localparam int KANJI_AW = $clog2(KANJI_BYTES);
  localparam int RAM_AW   = $clog2(RAM_BYTES);

  // cart index before reduction: {bank, offset}
  localparam int VAL_W     = BANK_W + OFFS_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_CART_RD  = 3'd0;
  localparam logic [OP_W-1:0] OP_RAM_RD   = 3'd1;
  localparam logic [OP_W-1:0] OP_MEM_WR   = 3'd2;
  localparam logic [OP_W-1:0] OP_IO_RD    = 3'd3;
  localparam logic [OP_W-1:0] OP_IO_WR    = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET    = 3'd5;
  localparam logic [OP_W-1:0] OP_LD_CART  = 3'd6;
  localparam logic [OP_W-1:0] OP_LD_KANJI = 3'd7;

  // I/O ports
  localparam logic [7:0] PORT_BANK_A   = 8'h70;
  localparam logic [7:0] PORT_BANK_B   = 8'h7f;
  localparam logic [7:0] PORT_PAGE     = 8'h77;
  localparam logic [7:0] PORT_KPTR     = 8'hfc;
  localparam logic [7:0] PORT_KANJI_EV = 8'hfd;
  localparam logic [7:0] PORT_KANJI_OD = 8'hfe;
  localparam logic [7:0] PORT_KANJI_EN = 8'hff;

  localparam logic [7:0] PAGE_NONE = 8'hff;
  localparam logic [7:0] BYTE_FF   = 8'hff;

  // 0x6000..0x7fff: address bits 15..13
  localparam logic [2:0] RAM_WIN = 3'b011;

endpackage

@@ design/banked_cartridge_bus_mapper_top.sv @@
// ---------------------------------------------------------------------------
// banked_cartridge_bus_mapper_top - cartridge mapper, one bus access per beat
// Bank/page/kanji registers with cart, kanji and work RAM stores.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_op/in_address/in_write_data with start high; the
//   beat is taken at the edge where start is high and busy is low.
//   Result channel: exactly one result per beat, held on the out_ ports for
//   one cycle with out_valid high. The receiver cannot stall it.
//   Writes, loads, register ops, page and disabled-kanji reads answer from
//   the execute state; cart reads, ram reads and enabled kanji reads read
//   their store there and answer from a further response state.
//   The cart index is wrapped to CART_BYTES on acceptance by a constant
//   table of bank bases and one compare and subtract.
//   busy is high from acceptance until the result is registered, so the
//   next beat may be taken at the edge that ends the result cycle.
//   Beats do not overlap: a new beat is taken only once the last has been answered.
//   Reset: the work RAM is cleared by a sweep over all RAM_BYTES (8192)
//   entries, one entry a cycle, with busy high. Cart and kanji stores are not
//   cleared; they must be loaded before being read.
// ---------------------------------------------------------------------------
module banked_cartridge_bus_mapper_top #(
  parameter int CART_BYTES = bcbm_pkg::CART_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bcbm_pkg::OP_W-1:0]     in_op,
  input  logic [bcbm_pkg::ADDR_W-1:0]   in_address,
  input  logic [bcbm_pkg::DATA_W-1:0]   in_write_data,
  output logic                          out_valid,
  output logic [bcbm_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_drive_bus,
  output logic                          out_load_request,
  output logic [bcbm_pkg::PAGE_W-1:0]   out_load_page
);

  import bcbm_pkg::*;

  localparam int CART_AW = $clog2(CART_BYTES);
  localparam int NBANKS  = 1 << BANK_W;
  localparam int SUM_W   = VAL_W + 1;

  typedef logic [NBANKS-1:0][VAL_W-1:0] base_tbl_t;

  // bank base already wrapped to the cart store size
  function automatic base_tbl_t bank_bases();
    base_tbl_t tbl;
    for (int b = 0; b < NBANKS; b++) begin
      tbl[b] = VAL_W'((b * BANK_BYTES) % CART_BYTES);
    end
    return tbl;
  endfunction

  localparam base_tbl_t BANK_BASE = bank_bases();

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [VAL_W-1:0]  modv_r, modv_nxt;
  logic [RAM_AW-1:0] clr_r, clr_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic [7:0]        page_r, page_nxt;
  logic [KPTR_W-1:0] kptr_r, kptr_nxt;
  logic              kon_r, kon_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0] ord_r, ord_nxt;
  logic              odrv_r, odrv_nxt;
  logic              oreq_r, oreq_nxt;
  logic [PAGE_W-1:0] opage_r, opage_nxt;

  logic [BANK_W-1:0] cbank;
  logic [SUM_W-1:0]  csum;
  logic [VAL_W-1:0]  cidx;
  logic [7:0]        port;

  logic                cart_we, ram_we, kanji_we;
  logic [CART_AW-1:0]  cart_addr;
  logic [RAM_AW-1:0]   ram_addr;
  logic [KANJI_AW-1:0] kanji_addr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   cart_rdata, ram_rdata, kanji_rdata;

  assign port = addr_r[7:0];

  // cart index: loads use address bits 16..13 in place of the bank
  always_comb begin
    cbank = (in_op == OP_LD_CART) ? BANK_W'(in_address[ADDR_W-1:OFFS_W]) : bank_r;
    csum  = SUM_W'(in_address[OFFS_W-1:0]) + {1'b0, BANK_BASE[cbank]};
    cidx  = (csum >= SUM_W'(CART_BYTES)) ? VAL_W'(csum - SUM_W'(CART_BYTES))
                                         : VAL_W'(csum);
  end

  // store ports
  always_comb begin
    cart_addr  = modv_r[CART_AW-1:0];
    cart_we    = (state_r == ST_EXEC) && (op_r == OP_LD_CART);
    kanji_we   = (state_r == ST_EXEC) && (op_r == OP_LD_KANJI);
    kanji_addr = (op_r == OP_LD_KANJI) ? addr_r[KANJI_AW-1:0]
                                       : {kptr_r, port == PORT_KANJI_OD};
    if (state_r == ST_CLEAR) begin
      ram_addr  = clr_r;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else begin
      ram_addr  = addr_r[RAM_AW-1:0];
      ram_we    = (state_r == ST_EXEC) && (op_r == OP_MEM_WR) &&
                  (addr_r[15:13] == RAM_WIN);
      ram_wdata = data_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    modv_nxt   = modv_r;
    clr_nxt    = clr_r;
    bank_nxt   = bank_r;
    page_nxt   = page_r;
    kptr_nxt   = kptr_r;
    kon_nxt    = kon_r;
    ovalid_nxt = 1'b0;
    ord_nxt    = '0;
    odrv_nxt   = 1'b0;
    oreq_nxt   = 1'b0;
    opage_nxt  = '0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == RAM_AW'(RAM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          addr_nxt  = in_address;
          data_nxt  = in_write_data;
          modv_nxt  = cidx;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_IDLE;
        ovalid_nxt = 1'b1;
        unique case (op_r)
          OP_CART_RD, OP_RAM_RD: begin
            ovalid_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end
          OP_IO_RD: begin
            priority if (port == PORT_PAGE) begin
              ord_nxt  = page_r;
              odrv_nxt = 1'b1;
            end else if (port == PORT_KANJI_EV || port == PORT_KANJI_OD) begin
              if (kon_r) begin
                ovalid_nxt = 1'b0;
                state_nxt  = ST_RESP;
              end else begin
                ord_nxt  = BYTE_FF;
                odrv_nxt = 1'b1;
              end
            end else begin
              odrv_nxt = 1'b0;
            end
          end
          OP_IO_WR: begin
            priority if (port == PORT_BANK_A || port == PORT_BANK_B) begin
              bank_nxt = data_r[BANK_W-1:0];
            end else if (port == PORT_PAGE) begin
              if (data_r != PAGE_NONE) begin
                page_nxt  = {2'b00, data_r[PAGE_W-1:0]};
                bank_nxt  = '0;
                oreq_nxt  = 1'b1;
                opage_nxt = data_r[PAGE_W-1:0];
              end else begin
                page_nxt = PAGE_NONE;
              end
            end else if (port == PORT_KPTR) begin
              kptr_nxt = {data_r, addr_r[15:8]};
            end else if (port == PORT_KANJI_EN) begin
              kon_nxt = (data_r != BYTE_FF);
            end else begin
              kon_nxt = kon_r;
            end
          end
          OP_RESET: begin
            bank_nxt = '0;
          end
          OP_MEM_WR, OP_LD_CART, OP_LD_KANJI: begin
            ord_nxt = '0;
          end
          default: begin
            ord_nxt = '0;
          end
        endcase
      end
      ST_RESP: begin
        state_nxt  = ST_IDLE;
        ovalid_nxt = 1'b1;
        odrv_nxt   = 1'b1;
        priority if (op_r == OP_CART_RD) begin
          ord_nxt = cart_rdata;
        end else if (op_r == OP_RAM_RD) begin
          ord_nxt = ram_rdata;
        end else begin
          ord_nxt = kanji_rdata;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      bank_r   <= '0;
      page_r   <= PAGE_NONE;
      kptr_r   <= '0;
      kon_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      bank_r   <= bank_nxt;
      page_r   <= page_nxt;
      kptr_r   <= kptr_nxt;
      kon_r    <= kon_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    addr_r  <= addr_nxt;
    data_r  <= data_nxt;
    modv_r  <= modv_nxt;
    ord_r   <= ord_nxt;
    odrv_r  <= odrv_nxt;
    oreq_r  <= oreq_nxt;
    opage_r <= opage_nxt;
  end

  bcbm_ram #(.WIDTH(DATA_W), .DEPTH(CART_BYTES)) u_cart (
    .clk   (clk),
    .we    (cart_we),
    .addr  (cart_addr),
    .wdata (data_r),
    .rdata (cart_rdata)
  );

  bcbm_ram #(.WIDTH(DATA_W), .DEPTH(KANJI_BYTES)) u_kanji (
    .clk   (clk),
    .we    (kanji_we),
    .addr  (kanji_addr),
    .wdata (data_r),
    .rdata (kanji_rdata)
  );

  bcbm_ram #(.WIDTH(DATA_W), .DEPTH(RAM_BYTES)) u_wram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ovalid_r;
  assign out_read_data    = ord_r;
  assign out_drive_bus    = odrv_r;
  assign out_load_request = oreq_r;
  assign out_load_page    = opage_r;

endmodule

@@ design/bcbm_ram.sv @@
// ---------------------------------------------------------------------------
// bcbm_ram - generic single-port synchronous RAM
// One access per cycle, write or read, read data registered.
// ---------------------------------------------------------------------------
module bcbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
